// ----- hdl/blt_pkg.sv -----
// ----------------------------------------------------------------------------
// blt_pkg
// Types, codes and byte classification shared by the line tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blt_pkg;

  // Byte class of the previous byte
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_OP    = 3'd1,
    CLS_ALPHA = 3'd2,
    CLS_NUM   = 3'd3,
    CLS_SPACE = 3'd4,
    CLS_QUOTE = 3'd5
  } blt_class_t;

  // What to do with the byte
  typedef enum logic [1:0] {
    ACT_DISCARD = 2'd0,
    ACT_START   = 2'd1,
    ACT_APPEND  = 2'd2
  } blt_action_t;

  // Kind of a token that is opened
  typedef enum logic [1:0] {
    KIND_OP     = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_NUMBER = 2'd2,
    KIND_STRING = 2'd3
  } blt_kind_t;

  // Character constants
  localparam logic [7:0] CH_QUOTE      = 8'h22;  // double quote
  localparam logic [7:0] CH_APOSTROPHE = 8'h27;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_GT         = 8'h3E;

  // Input beat
  typedef struct packed {
    logic [7:0] char_code;
    logic       line_start;
  } blt_in_t;

  // Result beat
  typedef struct packed {
    blt_action_t action;
    logic [7:0]  char_out;
    blt_kind_t   token_kind;
  } blt_out_t;

  // Tokenizer state carried from byte to byte
  typedef struct packed {
    blt_class_t last_class;
    logic       in_comment;
    logic [7:0] first_operator_char;
    logic       operator_single;
  } blt_state_t;

  localparam blt_state_t STATE_RESET = '{
    last_class:          CLS_NONE,
    in_comment:          1'b0,
    first_operator_char: 8'h00,
    operator_single:     1'b0
  };

  // Classify one byte
  function automatic blt_class_t classify(input logic [7:0] c);
    blt_class_t cls;
    if (c == CH_QUOTE) begin
      cls = CLS_QUOTE;
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      cls = CLS_SPACE;
    end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                 c == CH_UNDERSCORE) begin
      cls = CLS_ALPHA;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = CLS_NUM;
    end else begin
      cls = CLS_OP;
    end
    return cls;
  endfunction

  // Two-byte operators: <= << <> >> >=
  function automatic logic pair_merges(input logic [7:0] a, input logic [7:0] b);
    logic m;
    if (a == CH_LT) begin
      m = (b == CH_EQ) || (b == CH_LT) || (b == CH_GT);
    end else if (a == CH_GT) begin
      m = (b == CH_GT) || (b == CH_EQ);
    end else begin
      m = 1'b0;
    end
    return m;
  endfunction

  // Token kind for a class that opens a token
  function automatic blt_kind_t kind_of(input blt_class_t cls);
    blt_kind_t k;
    unique case (cls)
      CLS_ALPHA: k = KIND_WORD;
      CLS_NUM:   k = KIND_NUMBER;
      CLS_QUOTE: k = KIND_STRING;
      default:   k = KIND_OP;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/blt_step.sv -----
// ----------------------------------------------------------------------------
// blt_step
// Per-byte decision logic: result beat and next tokenizer state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blt_step
  import blt_pkg::*;
(
  input  blt_state_t cur_state,
  input  blt_in_t    item,
  output blt_out_t   result,
  output blt_state_t next_state
);

  blt_state_t st;
  blt_class_t cls;

  // Clear the state at the first byte of a line
  assign st  = item.line_start ? STATE_RESET : cur_state;
  assign cls = classify(item.char_code);

  // Decide the action and update the state
  always_comb begin
    next_state        = st;
    result.action     = ACT_DISCARD;
    result.char_out   = item.char_code;
    result.token_kind = KIND_OP;
    priority if (st.in_comment) begin
      result.action = ACT_DISCARD;
    end else if (st.last_class == CLS_QUOTE) begin
      // inside a string: everything is content, the closing quote ends it
      result.action = ACT_APPEND;
      if (item.char_code == CH_QUOTE) begin
        next_state.last_class = CLS_NONE;
      end
    end else if (item.char_code == CH_APOSTROPHE) begin
      next_state.in_comment = 1'b1;
    end else if (cls == CLS_SPACE) begin
      next_state.last_class = CLS_SPACE;
    end else if (cls == CLS_NUM && st.last_class == CLS_ALPHA) begin
      result.action = ACT_APPEND;
    end else if (item.char_code == CH_DOT && st.last_class == CLS_NUM) begin
      result.action = ACT_APPEND;
    end else if (cls != st.last_class) begin
      result.action     = ACT_START;
      result.token_kind = kind_of(cls);
      next_state.last_class = cls;
      if (cls == CLS_OP) begin
        next_state.first_operator_char = item.char_code;
        next_state.operator_single     = 1'b1;
      end
    end else if (cls == CLS_OP) begin
      // merge a two-byte operator, otherwise open a fresh one
      if (st.operator_single && pair_merges(st.first_operator_char, item.char_code)) begin
        result.action              = ACT_APPEND;
        next_state.operator_single = 1'b0;
      end else begin
        result.action                  = ACT_START;
        next_state.first_operator_char = item.char_code;
        next_state.operator_single     = 1'b1;
      end
    end else begin
      result.action = ACT_APPEND;
    end
  end

endmodule

// ----- hdl/basic_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// basic_line_tokenizer
// Byte-at-a-time tokenizer for line-oriented BASIC-style source text.
// ----------------------------------------------------------------------------
// Usage:
//   src_* carries one source byte per beat (char_code) with line_start set on
//   the first byte of each line. tok_* returns exactly one beat per source
//   byte: action (discard, start token, append), the byte echoed in char_out
//   and, on a token start, its kind.
//   Path: an accepted byte waits in the input register and moves into the
//   result register when that is free or being emptied; tok_* shows it there.
//   Throughput: one byte per cycle while tok_ready is high. The tokenizer
//   state loop (class, comment flag, open operator) closes through the
//   decision logic between the input register and the result register.
//   Stalls: while tok_ready is low the result beat holds, the input register
//   keeps one byte, and src_ready drops once both are full.
//   Reset (rst, synchronous): both registers empty, state back to no class,
//   no comment, no open operator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module basic_line_tokenizer
  import blt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_ready,
  input  blt_in_t  src_data,
  output logic     tok_valid,
  input  logic     tok_ready,
  output blt_out_t tok_data
);

  logic       hold_valid;
  blt_in_t    hold_data;
  blt_state_t state;
  blt_state_t state_next;
  blt_out_t   step_result;
  logic       advance;

  // Move a byte on when the result register is free or being emptied
  assign advance   = hold_valid && (!tok_valid || tok_ready);
  assign src_ready = !hold_valid || advance;

  blt_step u_step (
    .cur_state  (state),
    .item       (hold_data),
    .result     (step_result),
    .next_state (state_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (src_ready) begin
      hold_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      hold_data <= src_data;
    end
  end

  // Tokenizer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (advance) begin
      tok_valid <= 1'b1;
    end else if (tok_ready) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok_data <= step_result;
    end
  end

`ifndef SYNTH
  // A byte that moves on always lands in the result register
  a_advance_fills : assert property (@(posedge clk) disable iff (rst)
    advance |=> tok_valid)
    else $error("advanced byte did not reach the result register");

  // A held byte stays put while the result side is stalled
  a_hold_stable : assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !advance) |=> (hold_valid && $stable(hold_data)))
    else $error("held byte changed while stalled");

  // Bytes inside an open string are always appended
  a_string_append : assert property (@(posedge clk) disable iff (rst)
    (advance && !hold_data.line_start && !state.in_comment &&
     state.last_class == CLS_QUOTE) |=> (tok_data.action == ACT_APPEND))
    else $error("string byte not appended");

  // A kind other than operator is reported only on a token start
  a_kind_on_start : assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_data.action != ACT_START) |-> (tok_data.token_kind == KIND_OP))
    else $error("token kind set without a token start");
`endif

endmodule
